// ===== design/pps_pkg.sv =====
// Package for the plasma pixel unit: widths, phase constants, pipeline structs
// and the sine table builder. No dependencies.
`timescale 1ns / 1ps
package pps_pkg;

  localparam int COORD_BITS       = 12;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);
  localparam int ROOT_BITS        = COORD_BITS + 5;
  localparam int RAD_BITS         = 2 * ROOT_BITS;
  localparam int REM_BITS         = ROOT_BITS + 2;
  localparam int K_BITS           = 28;
  localparam int KR_BITS          = 24;

  localparam logic [K_BITS-1:0]  K_DIV7 = 28'd97652182;
  localparam logic [K_BITS-1:0]  K_DIV5 = 28'd136713055;
  localparam logic [K_BITS-1:0]  K_DIV6 = 28'd113927546;
  localparam logic [KR_BITS-1:0] K_RAD4 = 24'd10680707;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // config register indexes
  localparam logic [1:0] REG_TIME_PHASE   = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef logic signed [7:0] rom_t [SINE_TABLE_DEPTH];

  // values that ride along the square-root chain
  typedef struct packed {
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic        eor;
    logic        eof;
  } item_t;

  typedef struct packed {
    logic [RAD_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_t;

  // Taylor series for sin(pi/2 * f), f in Q30
  function automatic logic [63:0] quarter_sin(input logic [63:0] f30);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] s;
    a    = (f30 * HALF_PI_Q30) >> 30;
    a2   = (a * a) >> 30;
    term = a;
    s    = a;
    term = ((term * a2) >> 30) / 6;   s = s - term;
    term = ((term * a2) >> 30) / 20;  s = s + term;
    term = ((term * a2) >> 30) / 42;  s = s - term;
    term = ((term * a2) >> 30) / 72;  s = s + term;
    term = ((term * a2) >> 30) / 110; s = s - term;
    term = ((term * a2) >> 30) / 156; s = s + term;
    return s;
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] f30;
    logic [63:0] mag;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      n = 64'(i) * 4;
      q = n / SINE_TABLE_DEPTH;
      r = n % SINE_TABLE_DEPTH;
      if (q[0]) f30 = ((64'(SINE_TABLE_DEPTH) - r) << 30) / SINE_TABLE_DEPTH;
      else      f30 = (r << 30) / SINE_TABLE_DEPTH;
      if (f30 > ONE_Q30) f30 = ONE_Q30;
      mag = (127 * quarter_sin(f30) + (ONE_Q30 >> 1)) >> 30;
      if (mag > 127) mag = 127;
      rom[i] = (q >= 2) ? -8'(signed'(mag[7:0])) : 8'(signed'(mag[7:0]));
    end
    return rom;
  endfunction

endpackage

// ===== design/plasma_pattern_pixel_unit.sv =====
// Plasma pixel generator: phase products, 17-cell square-root chain, sine ROMs.
// Stages: squares, radius, the cell chain, radial phase, four ROM reads, output reg.
// One pixel per cycle unless out_ready_i stalls, via the per-stage handshake.
// Reset: control and valid bits cleared; time_phase 0, frame size 256 x 256.
// Depends on pps_pkg, pps_sqrt_cell and pps_sine_rom.
`timescale 1ns / 1ps
module plasma_pattern_pixel_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [pps_pkg::COORD_BITS-1:0] pixel_x_i,
  input  logic [pps_pkg::COORD_BITS-1:0] pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] rgba_word_o,
  output logic        end_of_row_o,
  output logic        end_of_frame_o
);

  localparam int CB = pps_pkg::COORD_BITS;
  localparam int NC = pps_pkg::ROOT_BITS;

  logic [15:0] time_q;
  logic [12:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= 16'd0;
      width_q  <= 13'd256;
      height_q <= 13'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pps_pkg::REG_TIME_PHASE:   time_q   <= cfg_data_i;
        pps_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i[12:0];
        pps_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // ---- stage 1: squares and linear phases
  logic v1_q, v2_q, vt1_q, vt2_q, vo_q;
  logic rdy1, rdy2, rdyt1, rdyt2, rdyo;
  logic [2*CB-1:0] xx_q, yy_q;
  pps_pkg::item_t  item1_d, item1_q, item2_q, itemt1_q, itemt2_q;
  logic [CB+pps_pkg::K_BITS-1:0] prod1, prod2;
  logic [CB+pps_pkg::K_BITS:0]   prod3;
  logic [CB:0]                   xy_sum;
  logic [12:0] w_last, h_last;

  assign w_last = width_q - 13'd1;
  assign h_last = height_q - 13'd1;
  assign xy_sum = (CB+1)'(pixel_x_i) + (CB+1)'(pixel_y_i);
  assign prod1  = (CB+pps_pkg::K_BITS)'(pixel_x_i)
                * (CB+pps_pkg::K_BITS)'(pps_pkg::K_DIV7);
  assign prod2  = (CB+pps_pkg::K_BITS)'(pixel_y_i)
                * (CB+pps_pkg::K_BITS)'(pps_pkg::K_DIV5);
  assign prod3  = (CB+pps_pkg::K_BITS+1)'(xy_sum)
                * (CB+pps_pkg::K_BITS+1)'(pps_pkg::K_DIV6);

  always_comb begin
    item1_d.p1  = prod1[31:16] + time_q;
    item1_d.p2  = prod2[31:16] - time_q;
    item1_d.p3  = prod3[31:16] - time_q;
    item1_d.eor = (13'(pixel_x_i) == w_last);
    item1_d.eof = (13'(pixel_x_i) == w_last) && (13'(pixel_y_i) == h_last);
  end

  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      xx_q    <= (2*CB)'(pixel_x_i) * (2*CB)'(pixel_x_i);
      yy_q    <= (2*CB)'(pixel_y_i) * (2*CB)'(pixel_y_i);
      item1_q <= item1_d;
    end
  end

  // ---- stage 2: radius squared, scaled by 256 for 4 fraction bits
  logic [2*CB:0]               sq_sum;
  logic [pps_pkg::RAD_BITS-1:0] rad_q;
  logic                        chain_ready [NC+1];
  logic                        chain_valid [NC+1];
  pps_pkg::sqrt_t              chain_sq    [NC+1];
  pps_pkg::item_t              chain_item  [NC+1];

  assign sq_sum = (2*CB+1)'(xx_q) + (2*CB+1)'(yy_q);
  assign rdy2   = ~v2_q | chain_ready[0];

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      rad_q   <= pps_pkg::RAD_BITS'({sq_sum, 8'd0});
      item2_q <= item1_q;
    end
  end

  assign chain_valid[0]   = v2_q;
  assign chain_sq[0].rad  = rad_q;
  assign chain_sq[0].rem  = '0;
  assign chain_sq[0].root = '0;
  assign chain_item[0]    = item2_q;
  assign chain_ready[NC]  = rdyt1;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    pps_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .sq_i    (chain_sq[k]),
      .item_i  (chain_item[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .sq_o    (chain_sq[k+1]),
      .item_o  (chain_item[k+1])
    );
  end

  // ---- radial phase
  logic [NC+pps_pkg::KR_BITS-1:0] prod4;
  logic [15:0] p4_q;

  assign prod4 = (NC+pps_pkg::KR_BITS)'(chain_sq[NC].root)
               * (NC+pps_pkg::KR_BITS)'(pps_pkg::K_RAD4);
  assign rdyt1 = ~vt1_q | rdyt2;

  always_ff @(posedge clk_i) begin
    if (rdyt1 && chain_valid[NC]) begin
      p4_q     <= prod4[31:16] - time_q;
      itemt1_q <= chain_item[NC];
    end
  end

  // ---- sine lookups
  logic en_rom;
  logic signed [7:0] s1, s2, s3, s4;

  assign rdyt2  = ~vt2_q | rdyo;
  assign en_rom = rdyt2 && vt1_q;

  pps_sine_rom u_rom1 (.clk_i(clk_i), .en_i(en_rom), .phase_i(itemt1_q.p1), .sine_o(s1));
  pps_sine_rom u_rom2 (.clk_i(clk_i), .en_i(en_rom), .phase_i(itemt1_q.p2), .sine_o(s2));
  pps_sine_rom u_rom3 (.clk_i(clk_i), .en_i(en_rom), .phase_i(itemt1_q.p3), .sine_o(s3));
  pps_sine_rom u_rom4 (.clk_i(clk_i), .en_i(en_rom), .phase_i(p4_q),        .sine_o(s4));

  always_ff @(posedge clk_i) begin
    if (en_rom) begin
      itemt2_q <= itemt1_q;
    end
  end

  // ---- sum of terms and output register
  logic [7:0] t1, t2, t3, t4;
  logic [9:0] tot;
  logic [7:0] val_q;
  logic       eor_q, eof_q;

  assign t1  = 8'(s1) + 8'd127;
  assign t2  = 8'(s2) + 8'd127;
  assign t3  = 8'(s3) + 8'd127;
  assign t4  = 8'(s4) + 8'd127;
  assign tot = 10'(t1) + 10'(t2) + 10'(t3) + 10'(t4);
  assign rdyo = ~vo_q | out_ready_i;

  always_ff @(posedge clk_i) begin
    if (rdyo && vt2_q) begin
      val_q <= tot[9:2];
      eor_q <= itemt2_q.eor;
      eof_q <= itemt2_q.eof;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      vt1_q <= 1'b0;
      vt2_q <= 1'b0;
      vo_q  <= 1'b0;
    end else begin
      if (rdy1)  v1_q  <= in_valid_i;
      if (rdy2)  v2_q  <= v1_q;
      if (rdyt1) vt1_q <= chain_valid[NC];
      if (rdyt2) vt2_q <= vt1_q;
      if (rdyo)  vo_q  <= vt2_q;
    end
  end

  assign out_valid_o    = vo_q;
  assign rgba_word_o    = {4{val_q}};
  assign end_of_row_o   = eor_q;
  assign end_of_frame_o = eof_q;

  // ---- checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result waiting");

  a_frame_implies_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> end_of_row_o)
    else $error("frame end without row end");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rgba_word_o[7:0] != 8'hFF))
    else $error("plasma value out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vt2_q && vo_q && !out_ready_i |=> vt2_q && $stable(itemt2_q))
    else $error("lookup stage lost an item under stall");

endmodule

// ===== design/pps_sqrt_cell.sv =====
// One cell of the square-root chain: retires one root bit per cell.
// Depends on pps_pkg.
`timescale 1ns / 1ps
module pps_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  pps_pkg::sqrt_t sq_i,
  input  pps_pkg::item_t item_i,
  output logic          valid_o,
  input  logic          ready_i,
  output pps_pkg::sqrt_t sq_o,
  output pps_pkg::item_t item_o
);

  logic            valid_q;
  pps_pkg::sqrt_t  sq_d, sq_q;
  pps_pkg::item_t  item_q;
  logic [pps_pkg::REM_BITS+1:0] cur, trial, diff;

  assign ready_o = ~valid_q | ready_i;

  always_comb begin
    cur   = {sq_i.rem, sq_i.rad[pps_pkg::RAD_BITS-1 -: 2]};
    trial = (pps_pkg::REM_BITS + 2)'({sq_i.root, 2'b01});
    diff  = cur - trial;
    sq_d.rad = sq_i.rad << 2;
    if (cur >= trial) begin
      sq_d.rem  = diff[pps_pkg::REM_BITS-1:0];
      sq_d.root = {sq_i.root[pps_pkg::ROOT_BITS-2:0], 1'b1};
    end else begin
      sq_d.rem  = cur[pps_pkg::REM_BITS-1:0];
      sq_d.root = {sq_i.root[pps_pkg::ROOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sq_q   <= sq_d;
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;
  assign item_o  = item_q;

endmodule

// ===== design/pps_sine_rom.sv =====
// Sine lookup cell: nearest-entry index from a 16-bit phase, registered ROM read.
// Depends on pps_pkg.
`timescale 1ns / 1ps
module pps_sine_rom (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [15:0]       phase_i,
  output logic signed [7:0] sine_o
);

  localparam pps_pkg::rom_t ROM = pps_pkg::build_rom();

  logic [16+pps_pkg::IDX_BITS:0] wide;
  logic [pps_pkg::IDX_BITS-1:0]  idx;
  logic signed [7:0]             sine_q;

  // rounding to the nearest entry; the top entry wraps to zero
  assign wide = ((17 + pps_pkg::IDX_BITS)'(phase_i) << pps_pkg::IDX_BITS)
              + (17 + pps_pkg::IDX_BITS)'(32768);
  assign idx  = wide[16 +: pps_pkg::IDX_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q <= ROM[idx];
    end
  end

  assign sine_o = sine_q;

endmodule
